// ----- hdl/fenwick_tree_sum_search_unit_defines.svh -----
// Assertion macros shared by the Fenwick tree unit.
// Every macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef FENWICK_TREE_SUM_SEARCH_UNIT_DEFINES_SVH
`define FENWICK_TREE_SUM_SEARCH_UNIT_DEFINES_SVH

// The condition must never hold outside reset.
`define FTS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fts_pkg.sv -----
package fts_pkg;

    localparam int ValueW = 64;
    localparam int PosW   = 10;
    localparam int FoundW = 11;

    localparam logic [1:0] KindAdd    = 2'd0;
    localparam logic [1:0] KindSum    = 2'd1;
    localparam logic [1:0] KindSearch = 2'd2;
    localparam logic [1:0] KindUnused = 2'd3;

    typedef struct packed {
        logic signed [ValueW-1:0] sum_value;
        logic [FoundW-1:0]        found_position;
        logic                     not_found;
        logic                     range_error;
    } t_result;

endpackage

// ----- hdl/fts_node_mem.sv -----
module fts_node_mem import fts_pkg::*; #(
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [ValueW-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [ValueW-1:0]        i_wr_data
);

    logic [ValueW-1:0] r_mem [Depth];
    logic [ValueW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/fts_out_reg.sv -----
module fts_out_reg import fts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hdl/fts_seq.sv -----
module fts_seq import fts_pkg::*; #(
    parameter int SIZE = 1023
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_kind,
    input  logic [PosW-1:0]              i_position,
    input  logic [PosW-1:0]              i_right_position,
    input  logic signed [ValueW-1:0]     i_value,
    output logic                         o_rd_en,
    output logic [$clog2(SIZE+1)-1:0]    o_rd_addr,
    input  logic [ValueW-1:0]            i_rd_data,
    output logic                         o_wr_en,
    output logic [$clog2(SIZE+1)-1:0]    o_wr_addr,
    output logic [ValueW-1:0]            o_wr_data,
    output logic                         o_push,
    output t_result                      o_result,
    input  logic                         i_out_ready
);

    localparam int Nodes  = SIZE + 1;
    localparam int AW     = $clog2(Nodes);
    localparam int CwMin  = AW + 2;
    localparam int CW     = (CwMin > FoundW) ? CwMin : FoundW;
    localparam int LogTop = $clog2(Nodes + 1) - 1;
    localparam logic [CW-1:0] NodesC = CW'(Nodes);
    localparam logic [CW-1:0] SizeC  = CW'(SIZE);
    localparam logic [CW-1:0] TopK   = CW'(1) << LogTop;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_SUM,
        S_SRCH,
        S_SCMP,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_node, n_node;
    logic [CW-1:0]     r_wnode, n_wnode;
    logic [CW-1:0]     r_left, n_left;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_k, n_k;
    logic              r_pend, n_pend;
    logic              r_neg, n_neg;
    logic              r_pend_neg, n_pend_neg;
    logic [ValueW-1:0] r_acc, n_acc;
    logic [ValueW-1:0] r_w, n_w;
    logic [ValueW-1:0] r_value, n_value;
    t_result           r_result, n_result;

    logic [CW-1:0] w_low_bit;
    logic [CW-1:0] w_probe;

    assign w_low_bit  = r_node & (~r_node + CW'(1));
    assign w_probe    = r_i + r_k;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_result   = r_result;

    always_comb begin
        n_state    = r_state;
        n_node     = r_node;
        n_wnode    = r_wnode;
        n_left     = r_left;
        n_i        = r_i;
        n_k        = r_k;
        n_pend     = r_pend;
        n_neg      = r_neg;
        n_pend_neg = r_pend_neg;
        n_acc      = r_acc;
        n_w        = r_w;
        n_value    = r_value;
        n_result   = r_result;
        o_rd_en    = 1'b0;
        o_rd_addr  = AW'(r_node - CW'(1));
        o_wr_en    = 1'b0;
        o_wr_addr  = AW'(r_wnode - CW'(1));
        o_wr_data  = i_rd_data + r_value;
        o_push     = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_node);
                o_wr_data = '0;
                n_node    = r_node + CW'(1);
                if (r_node == NodesC - CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_result = '0;
                    case (i_kind)
                        KindAdd: begin
                            if (CW'(i_position) > SizeC) begin
                                n_result.range_error = 1'b1;
                                n_state = S_FIN;
                            end else begin
                                n_node  = CW'(i_position) + CW'(1);
                                n_value = i_value;
                                n_pend  = 1'b0;
                                n_state = S_ADD;
                            end
                        end
                        KindSum: begin
                            if (CW'(i_position) > SizeC || CW'(i_right_position) > SizeC) begin
                                n_result.range_error = 1'b1;
                                n_state = S_FIN;
                            end else begin
                                n_node  = CW'(i_right_position) + CW'(1);
                                n_left  = CW'(i_position);
                                n_neg   = 1'b0;
                                n_pend  = 1'b0;
                                n_acc   = '0;
                                n_state = S_SUM;
                            end
                        end
                        KindSearch: begin
                            if (i_value <= 0) begin
                                n_state = S_FIN;
                            end else begin
                                n_i     = '0;
                                n_k     = TopK;
                                n_w     = i_value;
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                // The write of the previous node overlaps the read of the next, higher one.
                if (r_pend) begin
                    o_wr_en = 1'b1;
                end
                if (r_node <= NodesC) begin
                    o_rd_en = 1'b1;
                    n_wnode = r_node;
                    n_node  = r_node + w_low_bit;
                    n_pend  = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_SUM: begin
                // Addresses do not depend on data, so one node is read each cycle.
                if (r_pend) begin
                    n_acc = r_pend_neg ? (r_acc - i_rd_data) : (r_acc + i_rd_data);
                end
                if (r_node != '0) begin
                    o_rd_en    = 1'b1;
                    n_node     = r_node - w_low_bit;
                    n_pend     = 1'b1;
                    n_pend_neg = r_neg;
                end else if (!r_neg && r_left != '0) begin
                    n_node = r_left;
                    n_neg  = 1'b1;
                    n_pend = 1'b0;
                end else begin
                    n_pend             = 1'b0;
                    n_result           = '0;
                    n_result.sum_value = n_acc;
                    n_state            = S_FIN;
                end
            end
            S_SRCH: begin
                if (r_k == '0) begin
                    n_result                = '0;
                    n_result.found_position = FoundW'(r_i);
                    n_result.not_found      = (r_i >= NodesC);
                    n_state                 = S_FIN;
                end else if (w_probe <= NodesC) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(w_probe - CW'(1));
                    n_state   = S_SCMP;
                end else begin
                    n_k = r_k >> 1;
                end
            end
            S_SCMP: begin
                if ($signed(i_rd_data) < $signed(r_w)) begin
                    n_w = r_w - i_rd_data;
                    n_i = w_probe;
                end
                n_k     = r_k >> 1;
                n_state = S_SRCH;
            end
            S_FIN: begin
                o_push = i_out_ready;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_node     <= '0;
            r_pend     <= 1'b0;
            r_neg      <= 1'b0;
            r_pend_neg <= 1'b0;
            r_wnode    <= '0;
            r_left     <= '0;
            r_i        <= '0;
            r_k        <= '0;
            r_acc      <= '0;
            r_w        <= '0;
            r_value    <= '0;
            r_result   <= '0;
        end else begin
            r_state    <= n_state;
            r_node     <= n_node;
            r_pend     <= n_pend;
            r_neg      <= n_neg;
            r_pend_neg <= n_pend_neg;
            r_wnode    <= n_wnode;
            r_left     <= n_left;
            r_i        <= n_i;
            r_k        <= n_k;
            r_acc      <= n_acc;
            r_w        <= n_w;
            r_value    <= n_value;
            r_result   <= n_result;
        end
    end

endmodule

// ----- hdl/fenwick_tree_sum_search_unit.sv -----
// Channel  Dir  Handshake                  Payload
// request  in   i_in_valid / o_in_stall    kind, position, right_position, value
// result   out  o_out_valid / i_out_stall  sum_value, found_position, not_found, range_error
// After reset a clearing pass zeroes all SIZE+1 nodes of the node memory; no request is taken then.
// A point add reads and writes back each node on its upward path, the write of one overlapping the next read.
// A range sum reads one node per cycle over two downward paths.
// A search visits each level of the tree: S_SRCH reads the probed node if it is in range, S_SCMP compares it.
// One request is in work at a time; a finished result waits in the output register under stall.
module fenwick_tree_sum_search_unit import fts_pkg::*; #(
    parameter int SIZE = 1023
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic [PosW-1:0]          i_position,
    input  logic [PosW-1:0]          i_right_position,
    input  logic signed [ValueW-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [ValueW-1:0] o_sum_value,
    output logic [FoundW-1:0]        o_found_position,
    output logic                     o_not_found,
    output logic                     o_range_error
);

`include "fenwick_tree_sum_search_unit_defines.svh"

    localparam int Nodes = SIZE + 1;
    localparam int AW    = $clog2(Nodes);

    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [ValueW-1:0] w_rd_data;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [ValueW-1:0] w_wr_data;
    logic              w_push;
    logic              w_out_ready;
    t_result           w_result;
    t_result           w_out_result;
    logic              w_same_node;
    logic              w_in_take;
    logic              w_miss_out;
    logic              w_miss_pos_ok;
    logic              w_err_out;
    logic              w_err_clean;

    fts_seq #(
        .SIZE(SIZE)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_right_position (i_right_position),
        .i_value          (i_value),
        .o_rd_en          (w_rd_en),
        .o_rd_addr        (w_rd_addr),
        .i_rd_data        (w_rd_data),
        .o_wr_en          (w_wr_en),
        .o_wr_addr        (w_wr_addr),
        .o_wr_data        (w_wr_data),
        .o_push           (w_push),
        .o_result         (w_result),
        .i_out_ready      (w_out_ready)
    );

    fts_node_mem #(
        .Depth(Nodes)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    fts_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_out_result)
    );

    assign o_sum_value      = w_out_result.sum_value;
    assign o_found_position = w_out_result.found_position;
    assign o_not_found      = w_out_result.not_found;
    assign o_range_error    = w_out_result.range_error;

    assign w_same_node   = w_rd_en && w_wr_en && (w_rd_addr == w_wr_addr);
    assign w_in_take     = i_in_valid && !o_in_stall && (i_kind != KindUnused);
    assign w_miss_out    = o_out_valid && o_not_found;
    assign w_miss_pos_ok = (o_found_position == FoundW'(Nodes));
    assign w_err_out     = o_out_valid && o_range_error;
    assign w_err_clean   = (o_sum_value == '0) && !o_not_found;

    // The add walk must never read the node it is writing back in the same cycle.
    `FTS_ASSERT_NEVER(a_no_rw_collision, w_same_node, "node read and write collide")
    `FTS_ASSERT_NEXT(a_one_request, w_in_take, o_in_stall, "second request taken while busy")
    `FTS_ASSERT_SAME(a_not_found_pos, w_miss_out, w_miss_pos_ok, "search miss has wrong position")
    `FTS_ASSERT_SAME(a_error_clean, w_err_out, w_err_clean, "range error result carries data")

endmodule
